>>> rtl/msf2f_pkg.sv
package msf2f_pkg;

  // Widest character the clamp allows (1 to 7).
  localparam int MAX_DATA_BITS = 7;

  localparam int CODE_W   = 7;
  localparam int NBITS_W  = 3;
  localparam int ZCNT_W   = 5;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 7;

  // Register reset values
  localparam logic [CODE_W-1:0] RST_CHAR_OFFSET = 7'd32;
  localparam logic [NBITS_W-1:0] RST_DATA_BITS  = 3'd6;
  localparam logic [ZCNT_W-1:0] RST_LEAD_ZEROS  = 5'd16;
  localparam logic [ZCNT_W-1:0] RST_TRAIL_ZEROS = 5'd16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_OFFSET = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BITS   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_ZEROS  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_ZEROS = 4'd3;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_END   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAD,
    ST_DATA,
    ST_PARITY,
    ST_TRAIL
  } state_e;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_DATA,
    SEL_PARITY
  } emit_sel_e;

  typedef struct packed {
    logic      load_start;
    logic      load_char;
    logic      load_end;
    logic      load_trail;
    logic      emit;
    emit_sel_e sel;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic cnt_one;
    logic cnt_zero;
    logic lead_zero;
    logic nbits_zero;
    logic trail_zero;
  } dp_stat_t;

  // Data bits per character after the clamp.
  function automatic logic [NBITS_W-1:0] eff_bits(input logic [NBITS_W-1:0] n);
    logic [NBITS_W:0] lim;
    lim = (NBITS_W+1)'(MAX_DATA_BITS);
    if ({1'b0, n} > lim) begin
      return lim[NBITS_W-1:0];
    end
    return n;
  endfunction

endpackage

>>> rtl/magstripe_f2f_track_encoder.sv
// F2F (Aiken biphase) magnetic stripe track encoder. Feed items on the
// input channel: start (clears the LRC, sends lead_zeros clocking zeros),
// character (code minus char_offset mod 128, data_bits bits LSB first plus
// odd parity, folded into the LRC) and end (LRC character with its own odd
// parity, then trail_zeros zeros). Each bit leaves as one item carrying the
// bit and the two half-cell line levels; last marks the final bit of the
// input item. Line level starts low after reset. An item is accepted, then
// its bits leave over the single serial bit path, one cell per cycle while
// the output is not stalled. The longest item is an end: 7 data bits, its
// parity and then 31 trail zeros. An output register holds the latest bit,
// so the next item is taken while it waits.
// Items are taken one at a time; in_stall_o is high while one is in work.
// An unused command code is accepted and produces nothing. Config writes
// are always ready and belong only in idle periods.
module magstripe_f2f_track_encoder
  import msf2f_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Config write
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  // Input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic [CODE_W-1:0]    char_code_i,
  // Result items, one per bit cell
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 data_bit_o,
  output logic                 first_half_level_o,
  output logic                 second_half_level_o,
  output logic                 last_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready_o = 1'b1;

  // Sequencer: walks lead zeros, data bits, parity and trail zeros.
  msf2f_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // Config, LRC, shift/parity, bit counter, line level and output register.
  msf2f_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .char_code_i         (char_code_i),
    .cmd_i               (dp_cmd),
    .stat_o              (dp_stat),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .data_bit_o          (data_bit_o),
    .first_half_level_o  (first_half_level_o),
    .second_half_level_o (second_half_level_o),
    .last_o              (last_o)
  );

endmodule

>>> rtl/msf2f_ctrl.sv
module msf2f_ctrl
  import msf2f_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       cmd_i,
  output logic             in_stall_o,
  input  dp_stat_t         stat_i,
  output dp_cmd_t          cmd_o
);

  state_e state_q, state_d;
  logic   end_mode_q, end_mode_d;
  logic   in_fire;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      end_mode_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      end_mode_q <= end_mode_d;
    end
  end

  // Next state
  always_comb begin
    state_d    = state_q;
    end_mode_d = end_mode_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd_i)
            CMD_START: state_d = stat_i.lead_zero ? ST_IDLE : ST_LEAD;
            CMD_CHAR: begin
              state_d    = stat_i.nbits_zero ? ST_PARITY : ST_DATA;
              end_mode_d = 1'b0;
            end
            CMD_END: begin
              state_d    = stat_i.nbits_zero ? ST_PARITY : ST_DATA;
              end_mode_d = 1'b1;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_LEAD, ST_TRAIL: begin
        if (stat_i.slot_free && stat_i.cnt_one) state_d = ST_IDLE;
      end
      ST_DATA: begin
        if (stat_i.slot_free && stat_i.cnt_one) state_d = ST_PARITY;
      end
      ST_PARITY: begin
        if (stat_i.slot_free) begin
          state_d = (end_mode_q && !stat_i.trail_zero) ? ST_TRAIL : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o = '{load_start: 1'b0, load_char: 1'b0, load_end: 1'b0, load_trail: 1'b0,
              emit: 1'b0, sel: SEL_ZERO, last: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd_i)
            CMD_START: cmd_o.load_start = 1'b1;
            CMD_CHAR:  cmd_o.load_char  = 1'b1;
            CMD_END:   cmd_o.load_end   = 1'b1;
            default:   cmd_o.load_start = 1'b0;
          endcase
        end
      end
      ST_LEAD, ST_TRAIL: begin
        cmd_o.emit = stat_i.slot_free;
        cmd_o.sel  = SEL_ZERO;
        cmd_o.last = stat_i.cnt_one;
      end
      ST_DATA: begin
        cmd_o.emit = stat_i.slot_free;
        cmd_o.sel  = SEL_DATA;
      end
      ST_PARITY: begin
        cmd_o.emit       = stat_i.slot_free;
        cmd_o.sel        = SEL_PARITY;
        cmd_o.load_trail = stat_i.slot_free && end_mode_q && !stat_i.trail_zero;
        cmd_o.last       = !(end_mode_q && !stat_i.trail_zero);
      end
      default: cmd_o.emit = 1'b0;
    endcase
  end

`ifndef SYNTHESIS
  // A counted state never runs with an exhausted counter.
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LEAD || state_q == ST_DATA || state_q == ST_TRAIL) |-> !stat_i.cnt_zero)
    else $error("bit counter empty in a counted state");

  // The bit flagged last hands control back to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == ST_IDLE))
    else $error("last bit did not return to idle");
`endif

endmodule

>>> rtl/msf2f_dp.sv
module msf2f_dp
  import msf2f_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic [CODE_W-1:0]    char_code_i,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic                 data_bit_o,
  output logic                 first_half_level_o,
  output logic                 second_half_level_o,
  output logic                 last_o
);

  logic [CODE_W-1:0]  char_offset_q;
  logic [NBITS_W-1:0] data_bits_q;
  logic [ZCNT_W-1:0]  lead_zeros_q, trail_zeros_q;

  logic               line_q, line_d;
  logic [CODE_W-1:0]  lrc_q, lrc_d;
  logic [CODE_W-1:0]  shift_q, shift_d;
  logic               parity_q, parity_d;
  logic [ZCNT_W-1:0]  cnt_q, cnt_d;

  logic               out_valid_q, out_valid_d;
  logic               out_bit_q, out_first_q, out_second_q, out_last_q;

  logic [NBITS_W-1:0] nbits;
  logic [CODE_W-1:0]  char_val, char_mask;
  logic               bit_val, first_lvl, second_lvl, slot_free;

  assign nbits     = eff_bits(data_bits_q);
  assign char_val  = char_code_i - char_offset_q;
  assign char_mask = CODE_W'((8'd1 << nbits) - 8'd1);
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    case (cmd_i.sel)
      SEL_DATA:   bit_val = shift_q[0];
      SEL_PARITY: bit_val = parity_q;
      default:    bit_val = 1'b0;
    endcase
  end

  // Each cell opens with a transition; a one adds one at mid-cell.
  assign first_lvl  = !line_q;
  assign second_lvl = first_lvl ^ bit_val;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_offset_q <= RST_CHAR_OFFSET;
      data_bits_q   <= RST_DATA_BITS;
      lead_zeros_q  <= RST_LEAD_ZEROS;
      trail_zeros_q <= RST_TRAIL_ZEROS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CHAR_OFFSET: char_offset_q <= cfg_data_i;
        CFG_DATA_BITS:   data_bits_q   <= cfg_data_i[NBITS_W-1:0];
        CFG_LEAD_ZEROS:  lead_zeros_q  <= cfg_data_i[ZCNT_W-1:0];
        CFG_TRAIL_ZEROS: trail_zeros_q <= cfg_data_i[ZCNT_W-1:0];
        default:         char_offset_q <= char_offset_q;
      endcase
    end
  end

  always_comb begin
    line_d      = line_q;
    lrc_d       = lrc_q;
    shift_d     = shift_q;
    parity_d    = parity_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.load_start) begin
      lrc_d = '0;
      cnt_d = lead_zeros_q;
    end
    if (cmd_i.load_char) begin
      lrc_d    = lrc_q ^ (char_val & char_mask);
      shift_d  = char_val;
      parity_d = 1'b1;
      cnt_d    = ZCNT_W'(nbits);
    end
    if (cmd_i.load_end) begin
      shift_d  = lrc_q;
      parity_d = 1'b1;
      cnt_d    = ZCNT_W'(nbits);
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      line_d      = second_lvl;
      if (cmd_i.sel == SEL_DATA) begin
        parity_d = parity_q ^ shift_q[0];
        shift_d  = shift_q >> 1;
      end
      if (cmd_i.sel != SEL_PARITY) cnt_d = cnt_q - ZCNT_W'(1);
    end
    if (cmd_i.load_trail) cnt_d = trail_zeros_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= 1'b0;
      lrc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      line_q      <= line_d;
      lrc_q       <= lrc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q  <= shift_d;
    parity_q <= parity_d;
    if (cmd_i.emit) begin
      out_bit_q    <= bit_val;
      out_first_q  <= first_lvl;
      out_second_q <= second_lvl;
      out_last_q   <= cmd_i.last;
    end
  end

  assign stat_o = '{slot_free:  slot_free,
                    cnt_one:    (cnt_q == ZCNT_W'(1)),
                    cnt_zero:   (cnt_q == '0),
                    lead_zero:  (lead_zeros_q == '0),
                    nbits_zero: (nbits == '0),
                    trail_zero: (trail_zeros_q == '0)};

  assign out_valid_o         = out_valid_q;
  assign data_bit_o          = out_bit_q;
  assign first_half_level_o  = out_first_q;
  assign second_half_level_o = out_second_q;
  assign last_o              = out_last_q;

`ifndef SYNTHESIS
  // A cell's first half always inverts the level left by the previous cell.
  a_cell_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (out_first_q != $past(line_q)))
    else $error("cell did not open with a transition");

  // Never overwrite a held result.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> slot_free)
    else $error("emit into a full output register");
`endif

endmodule
